>>> src/fqs_pkg.sv
`default_nettype none

package fqs_pkg;

  localparam int DEPTH      = 256;
  localparam int COORD_BITS = 10;
  localparam int LABEL_BITS = 16;

  localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int REC_BITS = 2 * COORD_BITS + LABEL_BITS;

  // command codes
  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_PEEK   = 2'd2;
  localparam logic [1:0] CMD_SEARCH = 2'd3;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [LABEL_BITS-1:0] label;
  } fqs_in_t;

  typedef struct packed {
    logic                  ok;
    logic                  found;
    logic [COORD_BITS-1:0] head_row;
    logic [COORD_BITS-1:0] head_col;
    logic [LABEL_BITS-1:0] head_label;
    logic                  is_empty;
  } fqs_out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [LABEL_BITS-1:0] label;
  } fqs_rec_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;   // latch accepted word
    logic commit;     // finish the command, load result register
    logic rd_head;    // read head entry, start a scan
    logic scan_next;  // read next entry of the scan
  } fqs_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       empty;
    logic       match;
    logic       last;
    logic       out_free;
  } fqs_stat_t;

endpackage

`default_nettype wire

>>> src/fqs_ram.sv
`default_nettype none

module fqs_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 256
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     wr_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]                         wr_data_i,
  input  wire logic                                     rd_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]                         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/fqs_datapath.sv
`default_nettype none

module fqs_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fqs_pkg::fqs_in_t in_data_i,
  input  wire fqs_pkg::fqs_ctl_t ctl_i,
  output fqs_pkg::fqs_stat_t    stat_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output fqs_pkg::fqs_out_t     out_data_o
);

  import fqs_pkg::*;

  fqs_in_t               req_q;
  fqs_out_t              res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  logic [IDX_BITS-1:0]   head_q, head_d, tail_q, tail_d, scan_q, scan_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d, remain_q, remain_d;
  logic                  empty, full;
  fqs_rec_t              req_rec, rd_rec;
  logic [REC_BITS-1:0]   rd_data;
  logic                  ram_we, ram_re;
  logic [IDX_BITS-1:0]   rd_addr;

  function automatic logic [IDX_BITS-1:0] next_idx(input logic [IDX_BITS-1:0] i);
    if (i == IDX_BITS'(DEPTH - 1)) begin
      return '0;
    end
    return i + IDX_BITS'(1);
  endfunction

  assign empty   = (cnt_q == '0);
  assign full    = (cnt_q == CNT_BITS'(DEPTH));
  assign req_rec = '{row: req_q.row, col: req_q.col, label: req_q.label};
  assign rd_rec  = fqs_rec_t'(rd_data);

  assign ram_we  = ctl_i.commit && (req_q.cmd == CMD_PUSH) && !full;
  assign ram_re  = ctl_i.rd_head || ctl_i.scan_next;
  assign rd_addr = ctl_i.rd_head ? head_q : scan_q;

  fqs_ram #(
    .WIDTH (REC_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (tail_q),
    .wr_data_i (req_rec),
    .rd_en_i   (ram_re),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    scan_d      = scan_q;
    remain_d    = remain_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (ctl_i.rd_head) begin
      scan_d   = next_idx(head_q);
      remain_d = cnt_q;
    end else if (ctl_i.scan_next) begin
      scan_d   = next_idx(scan_q);
      remain_d = remain_q - CNT_BITS'(1);
    end

    if (ctl_i.commit) begin
      res_d = '0;
      case (req_q.cmd)
        CMD_PUSH: begin
          if (!full) begin
            tail_d   = next_idx(tail_q);
            cnt_d    = cnt_q + CNT_BITS'(1);
            res_d.ok = 1'b1;
          end
        end
        CMD_POP: begin
          if (!empty) begin
            head_d   = next_idx(head_q);
            cnt_d    = cnt_q - CNT_BITS'(1);
            res_d.ok = 1'b1;
          end
        end
        CMD_PEEK: begin
          if (!empty) begin
            res_d.ok         = 1'b1;
            res_d.head_row   = rd_rec.row;
            res_d.head_col   = rd_rec.col;
            res_d.head_label = rd_rec.label;
          end
        end
        CMD_SEARCH: begin
          res_d.found = !empty && (rd_rec == req_rec);
        end
        default: begin
          res_d = '0;
        end
      endcase
      res_d.is_empty = (cnt_d == '0);
      out_valid_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_req) begin
      req_q <= in_data_i;
    end
    scan_q   <= scan_d;
    remain_q <= remain_d;
    res_q    <= res_d;
  end

  assign stat_o.cmd      = req_q.cmd;
  assign stat_o.empty    = empty;
  assign stat_o.match    = (rd_rec == req_rec);
  assign stat_o.last     = (remain_q == CNT_BITS'(1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

>>> src/fqs_ctrl.sv
`default_nettype none

module fqs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire fqs_pkg::fqs_stat_t stat_i,
  output fqs_pkg::fqs_ctl_t       ctl_o
);

  import fqs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_PEEK = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load_req = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((stat_i.cmd == CMD_PUSH) || (stat_i.cmd == CMD_POP) || stat_i.empty) begin
          if (stat_i.out_free) begin
            ctl_o.commit = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          ctl_o.rd_head = 1'b1;
          state_d       = (stat_i.cmd == CMD_PEEK) ? S_PEEK : S_SCAN;
        end
      end
      S_PEEK: begin
        if (stat_i.out_free) begin
          ctl_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat_i.match || stat_i.last) begin
          if (stat_i.out_free) begin
            ctl_o.commit = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          ctl_o.scan_next = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> src/fifo_queue_with_search_core.sv
// Channel  | Handshake                  | Word
// ---------+----------------------------+------------------------------------------
// in       | in_valid_i / in_ready_o    | in_data_i  : cmd, row, col, label
// out      | out_valid_o / out_ready_i  | out_data_o : ok, found, head fields, is_empty
//
// Push and pop finish in EXEC, as do peek and search of an empty queue. Peek of
// a non-empty queue reads the head in EXEC and finishes in PEEK. Search reads up
// to N entries (N the queue occupancy): the scan reads one ring entry per cycle
// through the single read port of the entry RAM and stops at the first match.
// Reset empties the queue at once (head, tail and count cleared); entries are
// not cleared, only occupied ones are ever read.
// A new word is taken while a result waits in the output register; the next
// result stalls in its final state until that register is free.
`default_nettype none

module fifo_queue_with_search_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire fqs_pkg::fqs_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output fqs_pkg::fqs_out_t      out_data_o
);

  import fqs_pkg::*;

  // command / status between sequencer and datapath
  fqs_ctl_t  ctl;
  fqs_stat_t stat;

  // Sequencer: IDLE takes a word, EXEC resolves push/pop/empty cases or
  // starts a RAM read, PEEK and SCAN consume registered read data.
  fqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  // Datapath: ring pointers, occupancy, entry RAM, scan walker and the
  // output register.
  fqs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> src/fqs_checker.sv
`default_nettype none

module fqs_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_o,
  input  wire fqs_pkg::fqs_in_t  in_data_i,
  input  wire logic              out_valid_o,
  input  wire logic              out_ready_i,
  input  wire fqs_pkg::fqs_out_t out_data_o
);

  // waiting input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word changed while waiting");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a match only comes from a search of a non-empty queue
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |-> !out_data_o.ok && !out_data_o.is_empty)
    else $error("found with ok or empty queue");

  // head fields only from a successful peek
  a_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.head_row != '0) || (out_data_o.head_col != '0) ||
                    (out_data_o.head_label != '0))
    |-> out_data_o.ok && !out_data_o.found && !out_data_o.is_empty)
    else $error("head fields without successful peek");

  // one word at a time: no accept on the cycle after an accept
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("word accepted while busy");

endmodule

bind fifo_queue_with_search_core fqs_checker u_fqs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
